[rtl/core/dac_pkg.sv]
package dac_pkg;

  // Fixed sizes
  localparam int unsigned CONFIRM_COUNT  = 3;
  localparam int unsigned FEEDBACK_STEPS = 40;
  localparam int unsigned UID_BYTES      = 7;

  localparam int unsigned CNT_W  = $clog2(CONFIRM_COUNT + 1);
  localparam int unsigned FB_W   = 6;
  localparam int unsigned UID_W  = 8 * UID_BYTES;
  localparam int unsigned TICK_W = 32;

  // Configuration port
  localparam int unsigned NUM_REGS = 8;
  localparam int unsigned REG_IW   = $clog2(NUM_REGS);
  localparam int unsigned APB_DW   = 64;
  localparam int unsigned APB_AW   = REG_IW + 3;

  localparam logic [REG_IW-1:0] REG_SMOKE_THR  = REG_IW'(0);
  localparam logic [REG_IW-1:0] REG_PIR_THR    = REG_IW'(1);
  localparam logic [REG_IW-1:0] REG_OUTER_MOVE = REG_IW'(2);
  localparam logic [REG_IW-1:0] REG_OUTER_HOLD = REG_IW'(3);
  localparam logic [REG_IW-1:0] REG_INNER_MOVE = REG_IW'(4);
  localparam logic [REG_IW-1:0] REG_AUTH_UID   = REG_IW'(5);
  localparam logic [REG_IW-1:0] REG_AUTH_LEN   = REG_IW'(6);
  localparam logic [REG_IW-1:0] REG_GRACE      = REG_IW'(7);

  // Register reset values
  localparam logic [9:0]       RST_SMOKE_THR  = 10'd450;
  localparam logic [9:0]       RST_PIR_THR    = 10'd400;
  localparam logic [15:0]      RST_OUTER_MOVE = 16'd900;
  localparam logic [15:0]      RST_OUTER_HOLD = 16'd5000;
  localparam logic [15:0]      RST_INNER_MOVE = 16'd700;
  localparam logic [UID_W-1:0] RST_AUTH_UID   = UID_W'(32'h04F5_5EFB);
  localparam logic [2:0]       RST_AUTH_LEN   = 3'd4;
  localparam logic [7:0]       RST_GRACE      = 8'd80;

  typedef enum logic [1:0] {
    DS_CLOSED  = 2'd0,
    DS_OPENING = 2'd1,
    DS_OPEN    = 2'd2,
    DS_CLOSING = 2'd3
  } door_e;

  typedef enum logic [1:0] {
    FB_IDLE    = 2'd0,
    FB_GRANTED = 2'd1,
    FB_DENIED  = 2'd2
  } fb_e;

  localparam logic CMD_ACCESS = 1'b0;
  localparam logic CMD_SENSOR = 1'b1;

  typedef struct packed {
    logic [9:0]       smoke_thr;
    logic [9:0]       pir_thr;
    logic [15:0]      outer_move_ticks;
    logic [15:0]      outer_hold_ticks;
    logic [15:0]      inner_move_ticks;
    logic [UID_W-1:0] auth_uid;
    logic [2:0]       auth_uid_len;
    logic [7:0]       grace_steps;
  } dac_cfg_t;

  typedef struct packed {
    logic              cmd;
    logic [TICK_W-1:0] now_tick;
    logic              card_present;
    logic [3:0]        card_len;
    logic [UID_W-1:0]  card_uid;
    logic              button_level;
    logic [9:0]        smoke_sample;
    logic [9:0]        pir_sample;
    logic              laser_raw;
  } dac_in_t;

  typedef struct packed {
    logic [1:0] outer_state;
    logic [1:0] inner_state;
    logic       outer_open_cmd;
    logic       inner_open_cmd;
    logic [1:0] card_feedback;
    logic       smoke_detected;
    logic       motion_detected;
    logic       beam_broken;
    logic       fire_alarm;
    logic       intrusion_alarm;
    logic       buzzer_on;
    logic       armed;
  } dac_out_t;

endpackage

[rtl/core/dac_if.sv]
interface dac_in_if;
  import dac_pkg::*;

  logic    valid;
  logic    ready;
  dac_in_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface dac_out_if;
  import dac_pkg::*;

  logic     valid;
  logic     ready;
  dac_out_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

[rtl/core/dac_cfg_regs.sv]
module dac_cfg_regs (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [dac_pkg::APB_AW-1:0]   paddr,
  input  logic [dac_pkg::APB_DW-1:0]   pwdata,
  output logic [dac_pkg::APB_DW-1:0]   prdata,
  output logic                         pready,
  output dac_pkg::dac_cfg_t            cfg_o
);
  import dac_pkg::*;

  dac_cfg_t          cfg_q;
  logic              wr_en;
  logic [REG_IW-1:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[APB_AW-1:3];
  assign cfg_o   = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.smoke_thr        <= RST_SMOKE_THR;
      cfg_q.pir_thr          <= RST_PIR_THR;
      cfg_q.outer_move_ticks <= RST_OUTER_MOVE;
      cfg_q.outer_hold_ticks <= RST_OUTER_HOLD;
      cfg_q.inner_move_ticks <= RST_INNER_MOVE;
      cfg_q.auth_uid         <= RST_AUTH_UID;
      cfg_q.auth_uid_len     <= RST_AUTH_LEN;
      cfg_q.grace_steps      <= RST_GRACE;
    end else if (wr_en) begin
      case (reg_idx)
        REG_SMOKE_THR:  cfg_q.smoke_thr        <= pwdata[9:0];
        REG_PIR_THR:    cfg_q.pir_thr          <= pwdata[9:0];
        REG_OUTER_MOVE: cfg_q.outer_move_ticks <= pwdata[15:0];
        REG_OUTER_HOLD: cfg_q.outer_hold_ticks <= pwdata[15:0];
        REG_INNER_MOVE: cfg_q.inner_move_ticks <= pwdata[15:0];
        REG_AUTH_UID:   cfg_q.auth_uid         <= pwdata[UID_W-1:0];
        REG_AUTH_LEN:   cfg_q.auth_uid_len     <= pwdata[2:0];
        REG_GRACE:      cfg_q.grace_steps      <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_SMOKE_THR:  prdata = APB_DW'(cfg_q.smoke_thr);
      REG_PIR_THR:    prdata = APB_DW'(cfg_q.pir_thr);
      REG_OUTER_MOVE: prdata = APB_DW'(cfg_q.outer_move_ticks);
      REG_OUTER_HOLD: prdata = APB_DW'(cfg_q.outer_hold_ticks);
      REG_INNER_MOVE: prdata = APB_DW'(cfg_q.inner_move_ticks);
      REG_AUTH_UID:   prdata = APB_DW'(cfg_q.auth_uid);
      REG_AUTH_LEN:   prdata = APB_DW'(cfg_q.auth_uid_len);
      REG_GRACE:      prdata = APB_DW'(cfg_q.grace_steps);
      default:        prdata = '0;
    endcase
  end

endmodule

[rtl/core/dac_step_unit.sv]
module dac_step_unit (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  dac_pkg::dac_cfg_t cfg_i,
  input  logic              step_en_i,
  input  dac_pkg::dac_in_t  item_i,
  output dac_pkg::dac_out_t result_o
);
  import dac_pkg::*;

  function automatic logic [CNT_W-1:0] confirm_move(input logic [CNT_W-1:0] cnt,
                                                    input logic seen);
    logic [CNT_W-1:0] res;
    res = cnt;
    if (seen) begin
      if (cnt < CNT_W'(CONFIRM_COUNT)) res = cnt + CNT_W'(1);
    end else if (cnt != '0) begin
      res = cnt - CNT_W'(1);
    end
    return res;
  endfunction

  door_e             outer_q, outer_d, inner_q, inner_d;
  logic [TICK_W-1:0] outer_dl_q, outer_dl_d, inner_dl_q, inner_dl_d;
  logic              last_btn_q, last_btn_d;
  fb_e               fb_kind_q, fb_kind_d;
  logic [FB_W-1:0]   fb_cnt_q, fb_cnt_d;
  logic [7:0]        grace_q, grace_d;
  logic [CNT_W-1:0]  smoke_cnt_q, smoke_cnt_d;
  logic [CNT_W-1:0]  motion_cnt_q, motion_cnt_d;
  logic [CNT_W-1:0]  beam_cnt_q, beam_cnt_d;
  logic              blink_q, blink_d;
  logic              fire_q, fire_d, intr_q, intr_d, buzz_q, buzz_d;
  logic [1:0]        servo_q, servo_d;

  logic [TICK_W-1:0] now;
  logic [TICK_W-1:0] outer_move_at, outer_hold_at, inner_move_at;
  logic [UID_BYTES-1:0] byte_ok;
  logic              card_match;
  logic              btn_edge;
  logic              armed_d;

  assign now           = item_i.now_tick;
  assign outer_move_at = now + TICK_W'(cfg_i.outer_move_ticks);
  assign outer_hold_at = now + TICK_W'(cfg_i.outer_hold_ticks);
  assign inner_move_at = now + TICK_W'(cfg_i.inner_move_ticks);
  assign btn_edge      = !item_i.button_level && last_btn_q;

  // Bytes past the configured length do not take part.
  always_comb begin
    for (int i = 0; i < UID_BYTES; i++) begin
      byte_ok[i] = (item_i.card_uid[8*i +: 8] == cfg_i.auth_uid[8*i +: 8]) ||
                   (i >= int'(cfg_i.auth_uid_len));
    end
  end

  assign card_match = (item_i.card_len == {1'b0, cfg_i.auth_uid_len}) && (&byte_ok);

  always_comb begin
    outer_d      = outer_q;
    inner_d      = inner_q;
    outer_dl_d   = outer_dl_q;
    inner_dl_d   = inner_dl_q;
    last_btn_d   = last_btn_q;
    fb_kind_d    = fb_kind_q;
    fb_cnt_d     = fb_cnt_q;
    grace_d      = grace_q;
    smoke_cnt_d  = smoke_cnt_q;
    motion_cnt_d = motion_cnt_q;
    beam_cnt_d   = beam_cnt_q;
    blink_d      = blink_q;
    fire_d       = fire_q;
    intr_d       = intr_q;
    buzz_d       = buzz_q;
    servo_d      = servo_q;

    if (item_i.cmd == CMD_ACCESS) begin
      // Card feedback countdown
      if (fb_cnt_q != '0) begin
        fb_cnt_d = fb_cnt_q - FB_W'(1);
        if (fb_cnt_d == '0) fb_kind_d = FB_IDLE;
      end

      if (item_i.card_present) begin
        fb_cnt_d = FB_W'(FEEDBACK_STEPS);
        if (card_match) begin
          fb_kind_d = FB_GRANTED;
          grace_d   = cfg_i.grace_steps;
          if (outer_q == DS_CLOSED || outer_q == DS_CLOSING) begin
            servo_d[0] = 1'b1;
            outer_d    = DS_OPENING;
            outer_dl_d = outer_move_at;
          end else if (outer_q == DS_OPEN) begin
            outer_dl_d = outer_hold_at;
          end
        end else begin
          fb_kind_d = FB_DENIED;
        end
      end

      // Outer door timer
      case (outer_d)
        DS_OPENING: begin
          if (now >= outer_dl_d) begin
            outer_d    = DS_OPEN;
            outer_dl_d = outer_hold_at;
          end
        end
        DS_OPEN: begin
          if (now >= outer_dl_d) begin
            servo_d[0] = 1'b0;
            outer_d    = DS_CLOSING;
            outer_dl_d = outer_move_at;
          end
        end
        DS_CLOSING: begin
          if (now >= outer_dl_d) outer_d = DS_CLOSED;
        end
        default: ;
      endcase

      // Inner door: a press toggles it only while at rest
      if (btn_edge) begin
        if (inner_q == DS_CLOSED) begin
          servo_d[1] = 1'b1;
          inner_d    = DS_OPENING;
          inner_dl_d = inner_move_at;
          grace_d    = cfg_i.grace_steps;
        end else if (inner_q == DS_OPEN) begin
          servo_d[1] = 1'b0;
          inner_d    = DS_CLOSING;
          inner_dl_d = inner_move_at;
        end
      end
      last_btn_d = item_i.button_level;

      case (inner_d)
        DS_OPENING: if (now >= inner_dl_d) inner_d = DS_OPEN;
        DS_CLOSING: if (now >= inner_dl_d) inner_d = DS_CLOSED;
        default: ;
      endcase
    end else begin
      smoke_cnt_d  = confirm_move(smoke_cnt_q,
                                  item_i.smoke_sample >= cfg_i.smoke_thr);
      motion_cnt_d = confirm_move(motion_cnt_q,
                                  item_i.pir_sample >= cfg_i.pir_thr);
      beam_cnt_d   = confirm_move(beam_cnt_q, item_i.laser_raw);

      if (grace_q != '0) grace_d = grace_q - 8'd1;

      fire_d = smoke_cnt_d >= CNT_W'(CONFIRM_COUNT);
      intr_d = (grace_d == '0) && (outer_q == DS_CLOSED) && (inner_q == DS_CLOSED) &&
               ((motion_cnt_d >= CNT_W'(CONFIRM_COUNT)) ||
                (beam_cnt_d >= CNT_W'(CONFIRM_COUNT)));
      // Steady tone on fire, blink on intrusion
      if (fire_d) begin
        buzz_d = 1'b1;
      end else if (intr_d) begin
        blink_d = !blink_q;
        buzz_d  = blink_d;
      end else begin
        buzz_d  = 1'b0;
        blink_d = 1'b0;
      end
    end
  end

  assign armed_d = (grace_d == '0) && (outer_d == DS_CLOSED) && (inner_d == DS_CLOSED);

  always_comb begin
    result_o.outer_state     = outer_d;
    result_o.inner_state     = inner_d;
    result_o.outer_open_cmd  = servo_d[0];
    result_o.inner_open_cmd  = servo_d[1];
    result_o.card_feedback   = fb_kind_d;
    result_o.smoke_detected  = smoke_cnt_d >= CNT_W'(CONFIRM_COUNT);
    result_o.motion_detected = motion_cnt_d >= CNT_W'(CONFIRM_COUNT);
    result_o.beam_broken     = beam_cnt_d >= CNT_W'(CONFIRM_COUNT);
    result_o.fire_alarm      = fire_d;
    result_o.intrusion_alarm = intr_d;
    result_o.buzzer_on       = buzz_d;
    result_o.armed           = armed_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      outer_q      <= DS_CLOSED;
      inner_q      <= DS_CLOSED;
      outer_dl_q   <= '0;
      inner_dl_q   <= '0;
      last_btn_q   <= 1'b1;
      fb_kind_q    <= FB_IDLE;
      fb_cnt_q     <= '0;
      grace_q      <= '0;
      smoke_cnt_q  <= '0;
      motion_cnt_q <= '0;
      beam_cnt_q   <= '0;
      blink_q      <= 1'b0;
      fire_q       <= 1'b0;
      intr_q       <= 1'b0;
      buzz_q       <= 1'b0;
      servo_q      <= '0;
    end else if (step_en_i) begin
      outer_q      <= outer_d;
      inner_q      <= inner_d;
      outer_dl_q   <= outer_dl_d;
      inner_dl_q   <= inner_dl_d;
      last_btn_q   <= last_btn_d;
      fb_kind_q    <= fb_kind_d;
      fb_cnt_q     <= fb_cnt_d;
      grace_q      <= grace_d;
      smoke_cnt_q  <= smoke_cnt_d;
      motion_cnt_q <= motion_cnt_d;
      beam_cnt_q   <= beam_cnt_d;
      blink_q      <= blink_d;
      fire_q       <= fire_d;
      intr_q       <= intr_d;
      buzz_q       <= buzz_d;
      servo_q      <= servo_d;
    end
  end

`ifndef SYNTHESIS
  a_fb_idle_iff_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fb_cnt_q == '0) == (fb_kind_q == FB_IDLE))
    else $error("card feedback kind and countdown disagree");

  a_outer_servo: assert property (@(posedge clk_i) disable iff (!rst_ni)
    servo_q[0] == (outer_q == DS_OPENING || outer_q == DS_OPEN))
    else $error("outer servo command does not follow the door state");

  a_inner_servo: assert property (@(posedge clk_i) disable iff (!rst_ni)
    servo_q[1] == (inner_q == DS_OPENING || inner_q == DS_OPEN))
    else $error("inner servo command does not follow the door state");

  a_cnt_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    smoke_cnt_q <= CNT_W'(CONFIRM_COUNT) && motion_cnt_q <= CNT_W'(CONFIRM_COUNT) &&
    beam_cnt_q <= CNT_W'(CONFIRM_COUNT))
    else $error("confirm counter above its ceiling");

  a_buzz_needs_alarm: assert property (@(posedge clk_i) disable iff (!rst_ni)
    buzz_q |-> (fire_q || intr_q))
    else $error("buzzer on with no alarm");
`endif

endmodule

[rtl/core/door_access_and_alarm_controller.sv]
// Door access and alarm controller.
// Items arrive on in_i (valid/ready): cmd 0 is an access step (time stamp, card read,
// inner door button), cmd 1 is a sensor step (smoke, motion, laser). Every item gives
// exactly one result item on out_o with the door states, servo commands, card feedback,
// confirmed detections, alarm flags and the armed flag, all taken after the step.
// Configuration sits behind an APB-style port with 64-bit data; register i lives at byte
// address 8*i and is written on psel & penable & pwrite. pready is tied high. Write
// registers only while no item is in flight.
// Path: an item taken from in_i lands in the input register, is processed, and is then
// registered in the result register, where its result stays valid until it is taken.
// Throughput: one item per cycle while out_o.ready stays high; all step logic is a few
// compares, three 32-bit adds and small counters between the input and result registers.
// Stall: when out_o.ready is low the result register holds; the input register holds
// one more item, and in_i.ready drops only when both are full.
// Reset (rst_ni low, asynchronous): both doors closed, deadlines zero, button released,
// counters and alarms cleared, configuration back to its defaults, no item in flight.
module door_access_and_alarm_controller (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  dac_in_if.sink                     in_i,
  dac_out_if.source                  out_o,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [dac_pkg::APB_AW-1:0] paddr,
  input  logic [dac_pkg::APB_DW-1:0] pwdata,
  output logic [dac_pkg::APB_DW-1:0] prdata,
  output logic                       pready
);
  import dac_pkg::*;

  dac_cfg_t cfg;
  dac_out_t step_res;

  logic     in_valid_q, in_valid_d;
  dac_in_t  in_item_q;
  logic     out_valid_q, out_valid_d;
  dac_out_t out_res_q;
  logic     step_fire;
  logic     in_take;

  dac_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Advance the held item into the result register when that register is free
  // or is being emptied this cycle.
  assign step_fire   = in_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready  = !in_valid_q || step_fire;
  assign in_take     = in_i.valid && in_i.ready;
  assign in_valid_d  = in_take || (in_valid_q && !step_fire);
  assign out_valid_d = step_fire || (out_valid_q && !out_o.ready);

  dac_step_unit u_step (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg),
    .step_en_i (step_fire),
    .item_i    (in_item_q),
    .result_o  (step_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers: load only on a transfer, hold otherwise.
  always_ff @(posedge clk_i) begin
    if (in_take) in_item_q <= in_i.payload;
    if (step_fire) out_res_q <= step_res;
  end

  assign out_o.valid   = out_valid_q;
  assign out_o.payload = out_res_q;

endmodule

[test/door_alarm_checker.sv]
`timescale 1ns / 1ps

// Watches the item and result channels and the configuration port, predicts
// the status of the doors and alarms for every accepted item and compares it
// with the result items in order.
module door_alarm_checker
  import dac_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_ready_i,
  input  dac_in_t           in_item_i,
  input  logic              out_valid_i,
  input  logic              out_ready_i,
  input  dac_out_t          out_item_i,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  input  logic              pready,
  output int unsigned       mismatches_o,
  output int unsigned       pending_o
);

  dac_cfg_t cfg;

  door_e            outer_door, inner_door;
  logic [31:0]      outer_deadline, inner_deadline;
  logic             last_button;
  fb_e              fb_kind;
  logic [FB_W-1:0]  fb_count;
  logic [7:0]       grace_count;
  logic [CNT_W-1:0] smoke_cnt, motion_cnt, beam_cnt;
  logic             blink_phase;
  logic             fire_q, intrusion_q, buzzer_q;
  logic             outer_cmd, inner_cmd;

  dac_out_t    status_q[$];
  dac_out_t    predicted, oldest;
  int unsigned mismatch_count = 0;

  task automatic reset_model();
    cfg.smoke_thr        = RST_SMOKE_THR;
    cfg.pir_thr          = RST_PIR_THR;
    cfg.outer_move_ticks = RST_OUTER_MOVE;
    cfg.outer_hold_ticks = RST_OUTER_HOLD;
    cfg.inner_move_ticks = RST_INNER_MOVE;
    cfg.auth_uid         = RST_AUTH_UID;
    cfg.auth_uid_len     = RST_AUTH_LEN;
    cfg.grace_steps      = RST_GRACE;
    outer_door     = DS_CLOSED;
    inner_door     = DS_CLOSED;
    outer_deadline = '0;
    inner_deadline = '0;
    last_button    = 1'b1;
    fb_kind        = FB_IDLE;
    fb_count       = '0;
    grace_count    = '0;
    smoke_cnt      = '0;
    motion_cnt     = '0;
    beam_cnt       = '0;
    blink_phase    = 1'b0;
    fire_q         = 1'b0;
    intrusion_q    = 1'b0;
    buzzer_q       = 1'b0;
    outer_cmd      = 1'b0;
    inner_cmd      = 1'b0;
  endtask

  task automatic store_setting(input logic [REG_IW-1:0] idx, input logic [APB_DW-1:0] data);
    case (idx)
      REG_SMOKE_THR:  cfg.smoke_thr        = data[9:0];
      REG_PIR_THR:    cfg.pir_thr          = data[9:0];
      REG_OUTER_MOVE: cfg.outer_move_ticks = data[15:0];
      REG_OUTER_HOLD: cfg.outer_hold_ticks = data[15:0];
      REG_INNER_MOVE: cfg.inner_move_ticks = data[15:0];
      REG_AUTH_UID:   cfg.auth_uid         = data[UID_W-1:0];
      REG_AUTH_LEN:   cfg.auth_uid_len     = data[2:0];
      REG_GRACE:      cfg.grace_steps      = data[7:0];
      default: ;
    endcase
  endtask

  function automatic logic [CNT_W-1:0] confirm_step(input logic [CNT_W-1:0] cnt,
                                                    input logic seen);
    if (seen) begin
      if (cnt < CONFIRM_COUNT) return cnt + 1'b1;
      return cnt;
    end
    if (cnt != 0) return cnt - 1'b1;
    return cnt;
  endfunction

  function automatic logic card_matches(input logic [3:0] len, input logic [UID_W-1:0] uid);
    if (len != {1'b0, cfg.auth_uid_len}) return 1'b0;
    for (int i = 0; i < UID_BYTES && i < len; i++) begin
      if (uid[8*i +: 8] != cfg.auth_uid[8*i +: 8]) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic logic armed_now();
    return grace_count == 0 && outer_door == DS_CLOSED && inner_door == DS_CLOSED;
  endfunction

  task automatic access_update(input dac_in_t it);
    logic [31:0] now;
    now = it.now_tick;
    if (fb_count != 0) begin
      fb_count = fb_count - 1'b1;
      if (fb_count == 0) fb_kind = FB_IDLE;
    end
    if (it.card_present) begin
      fb_count = FB_W'(FEEDBACK_STEPS);
      if (card_matches(it.card_len, it.card_uid)) begin
        fb_kind     = FB_GRANTED;
        grace_count = cfg.grace_steps;
        if (outer_door == DS_CLOSED || outer_door == DS_CLOSING) begin
          outer_cmd      = 1'b1;
          outer_door     = DS_OPENING;
          outer_deadline = now + 32'(cfg.outer_move_ticks);
        end else if (outer_door == DS_OPEN) begin
          outer_deadline = now + 32'(cfg.outer_hold_ticks);
        end
      end else begin
        fb_kind = FB_DENIED;
      end
    end
    case (outer_door)
      DS_OPENING: if (now >= outer_deadline) begin
        outer_door     = DS_OPEN;
        outer_deadline = now + 32'(cfg.outer_hold_ticks);
      end
      DS_OPEN: if (now >= outer_deadline) begin
        outer_cmd      = 1'b0;
        outer_door     = DS_CLOSING;
        outer_deadline = now + 32'(cfg.outer_move_ticks);
      end
      DS_CLOSING: if (now >= outer_deadline) outer_door = DS_CLOSED;
      default: ;
    endcase
    if (!it.button_level && last_button) begin
      if (inner_door == DS_CLOSED) begin
        inner_cmd      = 1'b1;
        inner_door     = DS_OPENING;
        inner_deadline = now + 32'(cfg.inner_move_ticks);
        grace_count    = cfg.grace_steps;
      end else if (inner_door == DS_OPEN) begin
        inner_cmd      = 1'b0;
        inner_door     = DS_CLOSING;
        inner_deadline = now + 32'(cfg.inner_move_ticks);
      end
    end
    last_button = it.button_level;
    if (inner_door == DS_OPENING && now >= inner_deadline) inner_door = DS_OPEN;
    else if (inner_door == DS_CLOSING && now >= inner_deadline) inner_door = DS_CLOSED;
  endtask

  task automatic sensor_update(input dac_in_t it);
    logic fire, intrusion;
    smoke_cnt  = confirm_step(smoke_cnt, it.smoke_sample >= cfg.smoke_thr);
    motion_cnt = confirm_step(motion_cnt, it.pir_sample >= cfg.pir_thr);
    beam_cnt   = confirm_step(beam_cnt, it.laser_raw);
    if (grace_count != 0) grace_count = grace_count - 1'b1;
    fire      = smoke_cnt >= CONFIRM_COUNT;
    intrusion = armed_now() && (motion_cnt >= CONFIRM_COUNT || beam_cnt >= CONFIRM_COUNT);
    if (fire) begin
      buzzer_q = 1'b1;
    end else if (intrusion) begin
      blink_phase = ~blink_phase;
      buzzer_q    = blink_phase;
    end else begin
      buzzer_q    = 1'b0;
      blink_phase = 1'b0;
    end
    fire_q      = fire;
    intrusion_q = intrusion;
  endtask

  task automatic advance_controller(input dac_in_t it, output dac_out_t res);
    if (it.cmd == CMD_ACCESS) access_update(it);
    else sensor_update(it);
    res.outer_state     = outer_door;
    res.inner_state     = inner_door;
    res.outer_open_cmd  = outer_cmd;
    res.inner_open_cmd  = inner_cmd;
    res.card_feedback   = fb_kind;
    res.smoke_detected  = smoke_cnt >= CONFIRM_COUNT;
    res.motion_detected = motion_cnt >= CONFIRM_COUNT;
    res.beam_broken     = beam_cnt >= CONFIRM_COUNT;
    res.fire_alarm      = fire_q;
    res.intrusion_alarm = intrusion_q;
    res.buzzer_on       = buzzer_q;
    res.armed           = armed_now();
  endtask

  task automatic compare_field(input string name, input logic [1:0] want, input logic [1:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatch_count++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      reset_model();
      status_q.delete();
    end else begin
      if (psel && penable && pwrite && pready) store_setting(paddr[APB_AW-1:3], pwdata);
      if (in_valid_i && in_ready_i) begin
        advance_controller(in_item_i, predicted);
        status_q.push_back(predicted);
      end
      if (out_valid_i && out_ready_i) begin
        if (status_q.size() == 0) begin
          $error("result item arrived with no step waiting for it");
          mismatch_count++;
        end else begin
          oldest = status_q.pop_front();
          compare_field("outer_state", oldest.outer_state, out_item_i.outer_state);
          compare_field("inner_state", oldest.inner_state, out_item_i.inner_state);
          compare_field("outer_open_cmd", oldest.outer_open_cmd, out_item_i.outer_open_cmd);
          compare_field("inner_open_cmd", oldest.inner_open_cmd, out_item_i.inner_open_cmd);
          compare_field("card_feedback", oldest.card_feedback, out_item_i.card_feedback);
          compare_field("smoke_detected", oldest.smoke_detected, out_item_i.smoke_detected);
          compare_field("motion_detected", oldest.motion_detected, out_item_i.motion_detected);
          compare_field("beam_broken", oldest.beam_broken, out_item_i.beam_broken);
          compare_field("fire_alarm", oldest.fire_alarm, out_item_i.fire_alarm);
          compare_field("intrusion_alarm", oldest.intrusion_alarm, out_item_i.intrusion_alarm);
          compare_field("buzzer_on", oldest.buzzer_on, out_item_i.buzzer_on);
          compare_field("armed", oldest.armed, out_item_i.armed);
        end
      end
    end
    mismatches_o <= mismatch_count;
    pending_o    <= status_q.size();
  end

endmodule

[test/door_access_and_alarm_controller_tb.sv]
`timescale 1ns / 1ps

module door_access_and_alarm_controller_tb;
  import dac_pkg::*;

  localparam int unsigned CYCLE_LIMIT    = 200000;
  localparam int unsigned PHASES         = 6;
  localparam int unsigned ITEMS_PER_PHASE = 125;
  localparam int unsigned IN_W           = $bits(dac_in_t);

  logic clk_i = 1'b0;
  logic rst_ni;

  logic              psel, penable, pwrite;
  logic [APB_AW-1:0] paddr;
  logic [APB_DW-1:0] pwdata;
  logic [APB_DW-1:0] prdata;
  logic              pready;

  dac_in_if  in_ch ();
  dac_out_if out_ch ();

  int unsigned mismatches, pending;
  int unsigned cycle_count = 0;

  // Generator state: the setting the block holds now, the running time stamp,
  // the button level and the sensor moods that build confirm streaks.
  dac_cfg_t    setting;
  logic [31:0] tick_now;
  int unsigned tick_stride;
  logic        button_lvl;
  logic        smoke_high, pir_high, laser_high;
  logic        src_calm, sink_calm;

  always #1 clk_i = ~clk_i;

  door_access_and_alarm_controller dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_ch),
    .out_o   (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  door_alarm_checker checker_i (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_ch.valid),
    .in_ready_i   (in_ch.ready),
    .in_item_i    (in_ch.payload),
    .out_valid_i  (out_ch.valid),
    .out_ready_i  (out_ch.ready),
    .out_item_i   (out_ch.payload),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .pready       (pready),
    .mismatches_o (mismatches),
    .pending_o    (pending)
  );

  // Stop a hung run; the verdict below never gets here in a healthy one.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("door_access_and_alarm_controller regression: fail");
      $finish;
    end
  end

  // Result side: draw a stall per result item, sometimes switch to a calm
  // stretch where ready stays high.
  initial begin
    int unsigned stall;
    out_ch.ready <= 1'b0;
    sink_calm = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      stall = sink_calm ? 0 : $urandom_range(0, 16);
      if ($urandom_range(0, 39) == 0) sink_calm = ~sink_calm;
      if (stall != 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk_i); while (!(out_ch.valid && out_ch.ready));
    end
  end

  // Hand one item to the block: idle for a drawn gap, then hold valid until
  // the handshake. Valid stays high into the next call when it has no gap.
  task automatic send_step(input dac_in_t it);
    int unsigned gap;
    gap = src_calm ? 0 : $urandom_range(0, 16);
    if ($urandom_range(0, 39) == 0) src_calm = ~src_calm;
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_ch.payload <= it;
    in_ch.valid   <= 1'b1;
    do @(posedge clk_i); while (!(in_ch.valid && in_ch.ready));
  endtask

  // Drop valid and wait until every result item is back, then let the pipeline
  // settle.
  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  // Setup cycle, then access cycle; the write lands when pready is seen.
  // The bus returns to idle before the next transfer.
  task automatic write_reg(input logic [REG_IW-1:0] idx, input logic [APB_DW-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= APB_AW'({idx, 3'b000});
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic logic [UID_W-1:0] random_uid();
    return UID_W'({$urandom(), $urandom()});
  endfunction

  // Fields a step does not use still carry random content.
  function automatic dac_in_t noise_item();
    return dac_in_t'(IN_W'({$urandom(), $urandom(), $urandom(), $urandom()}));
  endfunction

  function automatic dac_in_t access_item(input logic [31:0] now, input logic card,
                                          input logic [3:0] len, input logic [UID_W-1:0] uid,
                                          input logic button);
    dac_in_t it;
    it              = noise_item();
    it.cmd          = CMD_ACCESS;
    it.now_tick     = now;
    it.card_present = card;
    it.card_len     = len;
    it.card_uid     = uid;
    it.button_level = button;
    return it;
  endfunction

  function automatic dac_in_t sensor_item(input logic [9:0] smoke, input logic [9:0] pir,
                                          input logic laser);
    dac_in_t it;
    it              = noise_item();
    it.cmd          = CMD_SENSOR;
    it.smoke_sample = smoke;
    it.pir_sample   = pir;
    it.laser_raw    = laser;
    return it;
  endfunction

  // Mostly land on the side of the threshold the mood asks for, now and then
  // anywhere. Nothing sits below a zero threshold.
  function automatic logic [9:0] draw_sample(input logic [9:0] thr, input logic high);
    if ($urandom_range(0, 7) == 0 || (!high && thr == 0)) return 10'($urandom());
    if (high) return 10'($urandom_range(thr, 1023));
    return 10'($urandom_range(0, thr - 1));
  endfunction

  // Build a card read: mostly the authorized card with random bytes past its
  // length, some with one wrong byte, some entirely random.
  task automatic draw_card(output logic [3:0] len, output logic [UID_W-1:0] uid);
    int unsigned kind, pos;
    kind = $urandom_range(0, 9);
    uid  = random_uid();
    if (kind >= 8) begin
      len = 4'($urandom_range(0, 15));
    end else begin
      len = {1'b0, setting.auth_uid_len};
      for (int i = 0; i < len; i++) uid[8*i +: 8] = setting.auth_uid[8*i +: 8];
      if (kind >= 6 && len != 0) begin
        pos = $urandom_range(0, len - 1);
        uid[8*pos +: 8] = uid[8*pos +: 8] ^ 8'($urandom_range(1, 255));
      end
    end
  endtask

  task automatic random_step(output dac_in_t it);
    logic [3:0]       len;
    logic [UID_W-1:0] uid;
    if ($urandom_range(0, 1) == 0) begin
      // Advance time; once in a while jump anywhere to hit stale and wrapped deadlines.
      if ($urandom_range(0, 39) == 0) tick_now = $urandom();
      else tick_now = tick_now + $urandom_range(0, tick_stride);
      if ($urandom_range(0, 2) == 0) button_lvl = ~button_lvl;
      draw_card(len, uid);
      it = access_item(tick_now, $urandom_range(0, 3) == 0, len, uid, button_lvl);
    end else begin
      if ($urandom_range(0, 7) == 0) smoke_high = ~smoke_high;
      if ($urandom_range(0, 7) == 0) pir_high = ~pir_high;
      if ($urandom_range(0, 7) == 0) laser_high = ~laser_high;
      it = sensor_item(draw_sample(setting.smoke_thr, smoke_high),
                       draw_sample(setting.pir_thr, pir_high),
                       $urandom_range(0, 7) == 0 ? 1'($urandom()) : laser_high);
    end
  endtask

  // First phase: every register at its minimum, so an empty card matches.
  // Second: every register at its maximum. The rest: short door timings and
  // a short grace so the alarms get armed often.
  task automatic pick_setting(input int unsigned phase);
    if (phase == 0) begin
      setting     = '0;
      tick_stride = 4;
    end else if (phase == 1) begin
      setting     = '1;
      tick_stride = 20000;
    end else begin
      setting.smoke_thr        = 10'($urandom_range(0, 1023));
      setting.pir_thr          = 10'($urandom_range(0, 1023));
      setting.outer_move_ticks = 16'($urandom_range(0, 64));
      setting.outer_hold_ticks = 16'($urandom_range(0, 200));
      setting.inner_move_ticks = 16'($urandom_range(0, 64));
      setting.auth_uid         = random_uid();
      setting.auth_uid_len     = 3'($urandom_range(0, 7));
      setting.grace_steps      = 8'($urandom_range(0, 12));
      tick_stride              = 40;
    end
    write_reg(REG_SMOKE_THR, APB_DW'(setting.smoke_thr));
    write_reg(REG_PIR_THR, APB_DW'(setting.pir_thr));
    write_reg(REG_OUTER_MOVE, APB_DW'(setting.outer_move_ticks));
    write_reg(REG_OUTER_HOLD, APB_DW'(setting.outer_hold_ticks));
    write_reg(REG_INNER_MOVE, APB_DW'(setting.inner_move_ticks));
    write_reg(REG_AUTH_UID, APB_DW'(setting.auth_uid));
    write_reg(REG_AUTH_LEN, APB_DW'(setting.auth_uid_len));
    write_reg(REG_GRACE, APB_DW'(setting.grace_steps));
  endtask

  initial begin
    dac_in_t          it;
    logic [UID_W-1:0] good_uid;
    rst_ni        <= 1'b0;
    in_ch.valid   <= 1'b0;
    in_ch.payload <= '0;
    psel          <= 1'b0;
    penable       <= 1'b0;
    pwrite        <= 1'b0;
    paddr         <= '0;
    pwdata        <= '0;
    src_calm   = 1'b0;
    button_lvl = 1'b1;
    smoke_high = 1'b0;
    pir_high   = 1'b0;
    laser_high = 1'b0;
    tick_now   = '0;
    good_uid   = RST_AUTH_UID;
    setting    = {RST_SMOKE_THR, RST_PIR_THR, RST_OUTER_MOVE, RST_OUTER_HOLD,
                  RST_INNER_MOVE, RST_AUTH_UID, RST_AUTH_LEN, RST_GRACE};
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed walk on the reset setting.
    // Full-scale sensors confirm smoke, motion and beam; fire holds the buzzer steady.
    repeat (3) send_step(sensor_item(10'd1023, 10'd1023, 1'b1));
    // Smoke just below threshold lets fire drop; intrusion blinks the buzzer.
    send_step(sensor_item(10'd449, 10'd1023, 1'b1));
    send_step(sensor_item(10'd0, 10'd399, 1'b0));
    // Samples exactly at the thresholds count as seen.
    send_step(sensor_item(10'd450, 10'd400, 1'b1));
    // Grant opens the outer door; a longer card is denied; a grant while
    // opening keeps the old deadline.
    send_step(access_item(32'd100, 1'b1, 4'd4, good_uid, 1'b1));
    send_step(access_item(32'd200, 1'b1, 4'd5, good_uid, 1'b1));
    send_step(access_item(32'd300, 1'b1, 4'd4, good_uid, 1'b1));
    send_step(access_item(32'd1000, 1'b0, 4'd0, '0, 1'b1));
    // Grant while open renews the hold.
    send_step(access_item(32'd2000, 1'b1, 4'd4, good_uid, 1'b1));
    // Button press opens the inner door; held and pressed-while-moving are ignored.
    send_step(access_item(32'd2000, 1'b0, 4'd0, '0, 1'b0));
    send_step(access_item(32'd2100, 1'b0, 4'd0, '0, 1'b0));
    send_step(access_item(32'd2200, 1'b0, 4'd0, '0, 1'b1));
    send_step(access_item(32'd2300, 1'b0, 4'd0, '0, 1'b0));
    send_step(access_item(32'd2800, 1'b0, 4'd0, '0, 1'b1));
    send_step(access_item(32'd2900, 1'b0, 4'd0, '0, 1'b0));
    send_step(access_item(32'd3700, 1'b0, 4'd0, '0, 1'b1));
    // Hold expires, then a grant while closing reopens.
    send_step(access_item(32'd7000, 1'b0, 4'd0, '0, 1'b1));
    send_step(access_item(32'd7100, 1'b1, 4'd4, good_uid, 1'b1));
    // Top time stamp with an all-ones over-long card: denied, and the hold
    // deadline wraps past zero, so a small time stamp starts closing the door.
    send_step(access_item(32'hFFFF_FFFF, 1'b1, 4'hF, '1, 1'b1));
    send_step(access_item(32'd5000, 1'b0, 4'd0, '0, 1'b1));
    repeat (2) send_step(sensor_item(10'd0, 10'd0, 1'b0));
    drain();

    for (int unsigned phase = 0; phase < PHASES; phase++) begin
      pick_setting(phase);
      repeat (ITEMS_PER_PHASE) begin
        random_step(it);
        send_step(it);
      end
      drain();
    end

    if (mismatches == 0 && pending == 0) begin
      $display("door_access_and_alarm_controller regression: pass");
    end else begin
      $display("door_access_and_alarm_controller regression: fail");
    end
    $finish;
  end

endmodule
